// File: src/smpq_pkg.sv
// Shared definitions for the stable min priority queue.
// Holds parameter defaults, command and status codes, and the control word type.
// No dependencies.
package smpq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int KEY_W_DEF  = 16;

  // Command codes on in_cmd.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes on out_status.
  typedef logic [1:0] status_t;
  localparam status_t ST_PUSHED = 2'd0;
  localparam status_t ST_POPPED = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;
  localparam status_t ST_FULL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture the incoming word.
    logic exec;   // Apply the captured command to the cell chain.
  } ctrl_t;

endpackage

// File: src/smpq_ctrl.sv
// Controller of the stable min priority queue.
// Sequences capture and execution of each word; uses smpq_pkg.
// Drives busy, the result strobe and the datapath commands.
module smpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output smpq_pkg::ctrl_t ctrl
);
  import smpq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic valid_r, valid_nxt;

  // Next state: a captured word passes through the execution state once and returns to idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    valid_nxt = (state_r == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Commands and handshake outputs.
  always_comb begin
    busy       = (state_r == S_EXEC);
    ctrl.load  = start && (state_r == S_IDLE);
    ctrl.exec  = (state_r == S_EXEC);
    out_valid  = valid_r;
  end

endmodule

// File: src/smpq_dp.sv
// Datapath of the stable min priority queue: a sorted chain of cells.
// Each cell holds a payload and a clamped key; uses smpq_pkg.
// Push inserts behind all equal keys, pop takes the head and shifts down.
module smpq_dp #(
  parameter int DEPTH  = smpq_pkg::DEPTH_DEF,
  parameter int DATA_W = smpq_pkg::DATA_W_DEF,
  parameter int KEY_W  = smpq_pkg::KEY_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smpq_pkg::ctrl_t            ctrl,
  input  logic                       in_cmd,
  input  logic [DATA_W-1:0]          in_data_in,
  input  logic signed [KEY_W-1:0]    in_key_in,
  output logic [DATA_W-1:0]          out_data_out,
  output smpq_pkg::status_t          out_status,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  output logic                       out_is_empty
);
  import smpq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int PRI_W = KEY_W - 1;

  // Captured word.
  logic              cmd_r;
  logic [DATA_W-1:0] data_r;
  logic [PRI_W-1:0]  key_r;

  // Cell chain, kept sorted by key and by arrival among equal keys.
  logic [DATA_W-1:0] pay_r   [DEPTH];
  logic [DATA_W-1:0] pay_nxt [DEPTH];
  logic [PRI_W-1:0]  pri_r   [DEPTH];
  logic [PRI_W-1:0]  pri_nxt [DEPTH];
  logic [DATA_W-1:0] pay_up  [DEPTH];
  logic [PRI_W-1:0]  pri_up  [DEPTH];
  logic [OCC_W-1:0]  cnt_r, cnt_nxt;

  logic [DEPTH-1:0]  le;
  logic [DEPTH-1:0]  prev_le;
  logic              full;

  logic [DATA_W-1:0] dout_r, dout_nxt;
  status_t           stat_r, stat_nxt;

  // Capture the word; a negative key becomes zero.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_cmd;
      data_r <= in_data_in;
      key_r  <= in_key_in[KEY_W-1] ? '0 : in_key_in[PRI_W-1:0];
    end
  end

  // Per-cell compare: a valid cell whose key is not above the new key stays put.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (OCC_W'(i) < cnt_r) && (pri_r[i] <= key_r);
    end
    prev_le = {le[DEPTH-2:0], 1'b1};
    full    = (cnt_r == OCC_W'(DEPTH));
  end

  // Neighbor taps for the insert shift.
  always_comb begin
    pay_up[0] = pay_r[0];
    pri_up[0] = pri_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      pay_up[i] = pay_r[i-1];
      pri_up[i] = pri_r[i-1];
    end
  end

  // Next chain contents, count and result.
  always_comb begin
    pay_nxt  = pay_r;
    pri_nxt  = pri_r;
    cnt_nxt  = cnt_r;
    dout_nxt = dout_r;
    stat_nxt = stat_r;
    if (ctrl.exec) begin
      dout_nxt = '0;
      if (cmd_r == CMD_PUSH) begin
        if (full) begin
          stat_nxt = ST_FULL;
        end else begin
          stat_nxt = ST_PUSHED;
          cnt_nxt  = cnt_r + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (!le[i]) begin
              if (prev_le[i]) begin
                pay_nxt[i] = data_r;
                pri_nxt[i] = key_r;
              end else begin
                pay_nxt[i] = pay_up[i];
                pri_nxt[i] = pri_up[i];
              end
            end
          end
        end
      end else begin
        if (cnt_r == '0) begin
          stat_nxt = ST_EMPTY;
        end else begin
          stat_nxt = ST_POPPED;
          dout_nxt = pay_r[0];
          cnt_nxt  = cnt_r - 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            pay_nxt[i] = pay_r[i+1];
            pri_nxt[i] = pri_r[i+1];
          end
        end
      end
    end
  end

  // Cells and result registers carry no reset; only the count does.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      pay_r[i] <= pay_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    dout_r <= dout_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result word.
  always_comb begin
    out_data_out  = dout_r;
    out_status    = stat_r;
    out_occupancy = cnt_r;
    out_is_empty  = (cnt_r == '0);
  end

endmodule

// File: src/stable_min_priority_queue.sv
// Stable min priority queue: a bounded store that returns the lowest key first.
// Top level; instantiates smpq_ctrl and smpq_dp, uses smpq_pkg.
//
// Usage:
//   A word is taken on a rising edge where start is high and busy is low.
//   in_cmd selects push or pop; a push stores in_data_in under in_key_in,
//   with a negative key stored as zero. A pop returns the entry with the
//   lowest key, the earliest pushed among equal keys.
//   Every word yields one result: out_valid is high for exactly one cycle
//   with out_data_out, out_status, out_occupancy and out_is_empty. The
//   receiver cannot stall, so the result must be taken in that cycle.
//   The accepting edge captures the word; the execution state applies it and
//   loads the result registers. busy is high for the single execution cycle,
//   in which the whole cell chain shifts at once; the next word can be taken
//   in the cycle that shows the previous result.
//   Reset (rst_n low, synchronous) empties the queue and clears busy and
//   out_valid. Stored payloads and keys are not cleared; only cells below
//   the occupancy are ever read.
module stable_min_priority_queue #(
  parameter int DEPTH      = smpq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = smpq_pkg::DATA_W_DEF,
  parameter int KEY_WIDTH  = smpq_pkg::KEY_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic [DATA_WIDTH-1:0]      in_data_in,
  input  logic signed [KEY_WIDTH-1:0] in_key_in,
  output logic                       out_valid,
  output logic [DATA_WIDTH-1:0]      out_data_out,
  output smpq_pkg::status_t          out_status,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  output logic                       out_is_empty
);
  import smpq_pkg::*;

  ctrl_t ctrl;

  // Sequencing.
  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // Sorted cell chain and result registers.
  smpq_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_WIDTH),
    .KEY_W  (KEY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_cmd        (in_cmd),
    .in_data_in    (in_data_in),
    .in_key_in     (in_key_in),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty)
  );

endmodule

// File: src/smpq_chk.sv
// Port-level checks for the stable min priority queue.
// Uses smpq_pkg; bound to stable_min_priority_queue at the end of this file.
module smpq_chk #(
  parameter int DEPTH      = smpq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = smpq_pkg::DATA_W_DEF,
  parameter int KEY_WIDTH  = smpq_pkg::KEY_W_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_cmd,
  input logic [DATA_WIDTH-1:0]      in_data_in,
  input logic signed [KEY_WIDTH-1:0] in_key_in,
  input logic                       out_valid,
  input logic [DATA_WIDTH-1:0]      out_data_out,
  input smpq_pkg::status_t          out_status,
  input logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  input logic                       out_is_empty
);
  import smpq_pkg::*;

  // An accepted word produces its result strobe once its execution state is over.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result strobe missing two cycles after accept");

  // Busy covers a single execution cycle.
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // The empty flag agrees with the occupancy.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // Only a successful pop returns a payload.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_POPPED) |-> (out_data_out == '0))
    else $error("nonzero payload on a result that is not a pop");

endmodule

bind stable_min_priority_queue smpq_chk #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .KEY_WIDTH  (KEY_WIDTH)
) u_smpq_chk (.*);

// File: tb/sv/stable_min_priority_queue_tb.sv
`timescale 1ns / 100ps
// Testbench for the stable min priority queue: directed table, then random push/pop traffic.
// Results are checked against an in-bench queue predictor; depends on smpq_pkg and the top level.
module stable_min_priority_queue_tb;
  import smpq_pkg::*;

  localparam int Q_DEPTH     = DEPTH_DEF;
  localparam int DATA_W      = DATA_W_DEF;
  localparam int KEY_W       = KEY_W_DEF;
  localparam int OCC_W       = $clog2(Q_DEPTH + 1);
  localparam int RAND_WORDS  = 1580;
  localparam int QUIET_TAIL  = 200;
  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_WAIT  = 8;

  // One result word as the block reports it.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [OCC_W-1:0]  occ;
    logic              empty;
  } qresult_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic              typed;
    qresult_t          result;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     in_cmd = CMD_PUSH;
  logic [DATA_W-1:0]        in_data_in = '0;
  logic signed [KEY_W-1:0]  in_key_in = '0;
  logic                     busy;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_data_out;
  status_t                  out_status;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_is_empty;

  // Predictor copy of the store, kept in arrival order.
  logic [DATA_W-1:0] stored_payload [Q_DEPTH];
  logic [KEY_W-2:0]  stored_key     [Q_DEPTH];
  int                stored_count = 0;

  qresult_t results_due [$];
  dir_row_t directed_rows [$];
  int       mismatch_count = 0;
  int       stall_cycles = 0;

  stable_min_priority_queue u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_data_in   (in_data_in),
    .in_key_in    (in_key_in),
    .out_valid    (out_valid),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_occupancy(out_occupancy),
    .out_is_empty (out_is_empty)
  );

  always #10 clk = ~clk;

  // Apply one word to the predictor store and return the result it should produce.
  function automatic qresult_t apply_queue_word(logic cmd, logic [DATA_W-1:0] data,
                                                logic [KEY_W-1:0] key);
    qresult_t         r;
    logic [KEY_W-2:0] clamped;
    int               best;
    r = '0;
    if (cmd == CMD_PUSH) begin
      // A set sign bit means the key is stored as zero.
      clamped = key[KEY_W-1] ? '0 : key[KEY_W-2:0];
      if (stored_count >= Q_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        stored_payload[stored_count] = data;
        stored_key[stored_count]     = clamped;
        stored_count++;
        r.status = ST_PUSHED;
      end
    end else if (stored_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Strict compare keeps the oldest entry among equal minimum keys.
      best = 0;
      for (int i = 1; i < stored_count; i++) begin
        if (stored_key[i] < stored_key[best]) best = i;
      end
      r.data = stored_payload[best];
      for (int i = best; i + 1 < stored_count; i++) begin
        stored_payload[i] = stored_payload[i+1];
        stored_key[i]     = stored_key[i+1];
      end
      stored_count--;
      r.status = ST_POPPED;
    end
    r.occ   = OCC_W'(stored_count);
    r.empty = (stored_count == 0);
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic cmd, logic [DATA_W-1:0] data,
                                         logic [KEY_W-1:0] key, logic [DATA_W-1:0] exp_data,
                                         status_t exp_status, int exp_occ);
    dir_row_t row;
    row.cmd    = cmd;
    row.data   = data;
    row.key    = key;
    row.typed  = 1'b1;
    row.result = '{data: exp_data, status: exp_status, occ: OCC_W'(exp_occ),
                   empty: (exp_occ == 0)};
    return row;
  endfunction

  function automatic dir_row_t checked_row(logic cmd, logic [DATA_W-1:0] data,
                                           logic [KEY_W-1:0] key);
    dir_row_t row;
    row        = '0;
    row.cmd    = cmd;
    row.data   = data;
    row.key    = key;
    return row;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(dir_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Offer one word and hold it until the block takes it; start stays high afterwards.
  task automatic send_word(logic cmd, logic [DATA_W-1:0] data, logic [KEY_W-1:0] key,
                           logic typed, qresult_t typed_result);
    qresult_t predicted;
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_data_in <= data;
    in_key_in  <= key;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_queue_word(cmd, data, key);
    if (typed) predicted = typed_result;
    results_due = {results_due, predicted};
  endtask

  task automatic sender_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    qresult_t due;
    if (rst_n && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got data %h status %0d occ %0d empty %0d",
                 $time, out_data_out, out_status, out_occupancy, out_is_empty);
        mismatch_count++;
      end else begin
        due = results_due.pop_front();
        if (out_data_out !== due.data) begin
          $display("%0t: data_out mismatch, expected %h, got %h", $time, due.data, out_data_out);
          mismatch_count++;
        end
        if (out_status !== due.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, due.status, out_status);
          mismatch_count++;
        end
        if (out_occupancy !== due.occ) begin
          $display("%0t: occupancy mismatch, expected %0d, got %0d", $time, due.occ,
                   out_occupancy);
          mismatch_count++;
        end
        if (out_is_empty !== due.empty) begin
          $display("%0t: is_empty mismatch, expected %0d, got %0d", $time, due.empty,
                   out_is_empty);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing is taken or returned for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, random traffic, then drain and report.
  initial begin : stimulus
    int               sent;
    int               block_len;
    int               push_pct;
    int               key_mode;
    bit               gaps_on;
    logic             cmd;
    logic [KEY_W-1:0] key;

    // Pop on empty, key extremes, clamped negatives tied with zero, fill and overflow.
    add_row(typed_row(CMD_POP,  32'hDEADBEEF, 16'h1234, '0, ST_EMPTY, 0));
    add_row(typed_row(CMD_PUSH, 32'hFFFFFFFF, 16'h7FFF, '0, ST_PUSHED, 1));
    add_row(typed_row(CMD_PUSH, 32'h00000000, 16'h8000, '0, ST_PUSHED, 2));
    add_row(typed_row(CMD_PUSH, 32'hA5A5A5A5, 16'hFFFF, '0, ST_PUSHED, 3));
    add_row(typed_row(CMD_PUSH, 32'h5A5A5A5A, 16'h0000, '0, ST_PUSHED, 4));
    add_row(checked_row(CMD_PUSH, 32'h10000000, 16'h0001));
    add_row(checked_row(CMD_PUSH, 32'h10000001, 16'h4000));
    add_row(checked_row(CMD_PUSH, 32'h10000002, 16'h0002));
    add_row(checked_row(CMD_PUSH, 32'h10000003, 16'h0001));
    add_row(checked_row(CMD_PUSH, 32'h10000004, 16'h7FFE));
    add_row(checked_row(CMD_PUSH, 32'h10000005, 16'h0003));
    add_row(checked_row(CMD_PUSH, 32'h10000006, 16'h0001));
    add_row(checked_row(CMD_PUSH, 32'h10000007, 16'h2AAA));
    add_row(checked_row(CMD_PUSH, 32'h10000008, 16'h5555));
    add_row(checked_row(CMD_PUSH, 32'h10000009, 16'h0002));
    add_row(checked_row(CMD_PUSH, 32'h1000000A, 16'h7FFF));
    add_row(checked_row(CMD_PUSH, 32'h1000000B, 16'h0000));
    add_row(typed_row(CMD_PUSH, 32'hCAFEF00D, 16'h0005, '0, ST_FULL, 16));
    add_row(typed_row(CMD_POP,  32'hFFFFFFFF, 16'hFFFF, '0, ST_POPPED, 15));
    add_row(typed_row(CMD_POP,  32'h0, 16'h0, 32'hA5A5A5A5, ST_POPPED, 14));
    add_row(typed_row(CMD_POP,  32'h0, 16'h0, 32'h5A5A5A5A, ST_POPPED, 13));
    add_row(checked_row(CMD_POP, 32'h12345678, 16'h8001));
    add_row(checked_row(CMD_POP, 32'h0, 16'h0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].key,
                directed_rows[i].typed, directed_rows[i].result);
    end
    // Let the queue report everything before random traffic starts.
    wait_for_results();

    // Random blocks, each with its own push bias, key style and gap pattern.
    sent = 0;
    while (sent < RAND_WORDS) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      key_mode  = $urandom_range(0, 2);
      gaps_on   = (sent < RAND_WORDS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      block_len = $urandom_range(20, 60);
      for (int n = 0; n < block_len && sent < RAND_WORDS; n++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        // Narrow keys force many ties; extremes hit the clamp boundary.
        case (key_mode)
          0: key = ($urandom_range(0, 4) == 0) ? KEY_W'(~$urandom_range(0, 3))
                                               : KEY_W'($urandom_range(0, 3));
          1: key = KEY_W'($urandom);
          default: begin
            case ($urandom_range(0, 5))
              0: key = 16'h0000;
              1: key = 16'h7FFF;
              2: key = 16'h8000;
              3: key = 16'hFFFF;
              4: key = 16'h0001;
              default: key = KEY_W'($urandom);
            endcase
          end
        endcase
        // The tail of the run goes without idle cycles.
        if (gaps_on && sent < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          sender_gap($urandom_range(1, 13));
        end
        send_word(cmd, DATA_W'($urandom), key, 1'b0, '0);
        sent++;
      end
      if (sent < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 7) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
